>>> rtl/capm_pkg.sv
// Package: shared constants, types and float compare helpers for the cube permute unit.
package capm_pkg;

    localparam int DIM_BITS_DEF = 12;
    localparam int AXES_DEF     = 4;
    localparam int MAX_AXES     = 4;
    localparam int SIZE_W       = 13;
    localparam int SRC_W        = 2;
    localparam int COORD_W      = 12;
    localparam int PIX_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 13;
    localparam logic [7:0] FILL_BYTE = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE0 = 3'd0,
        REG_SIZE1 = 3'd1,
        REG_SIZE2 = 3'd2,
        REG_SIZE3 = 3'd3,
        REG_SRC0  = 3'd4,
        REG_SRC1  = 3'd5,
        REG_SRC2  = 3'd6,
        REG_SRC3  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [COORD_W-1:0] dest_coord0;
        logic [COORD_W-1:0] dest_coord1;
        logic [COORD_W-1:0] dest_coord2;
        logic [COORD_W-1:0] dest_coord3;
        logic [PIX_W-1:0]   value_bits;
        logic [PIX_W-1:0]   running_min;
        logic [PIX_W-1:0]   running_max;
        logic               extrema_valid;
        logic               cube_last;
    } result_t;

    // Build the NaN replacement pattern from the fill byte.
    function automatic logic [PIX_W-1:0] fill_pattern();
        fill_pattern = {8{FILL_BYTE}};
    endfunction

    function automatic logic is_nan(input logic [PIX_W-1:0] b);
        is_nan = (&b[62:52]) && (|b[51:0]);
    endfunction

    // Strict double a < b for non-NaN operands; signed zeros compare equal.
    function automatic logic dbl_lt(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        logic both_zero;
        both_zero = (a[62:0] == '0) && (b[62:0] == '0);
        if (both_zero)
            dbl_lt = 1'b0;
        else if (a[63] != b[63])
            dbl_lt = a[63];
        else if (!a[63])
            dbl_lt = a[62:0] < b[62:0];
        else
            dbl_lt = a[62:0] > b[62:0];
    endfunction

endpackage

>>> rtl/capm_stream_if.sv
// Interface: valid/ready stream channel with a generic payload.
interface capm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/capm_counter.sv
// Module: raster position counters with wrap at effective axis sizes.
module capm_counter #(
    parameter int DIM_BITS = capm_pkg::DIM_BITS_DEF,
    parameter int AXES     = capm_pkg::AXES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic [capm_pkg::MAX_AXES-1:0][capm_pkg::SIZE_W-1:0] size,
    output logic [capm_pkg::MAX_AXES-1:0][DIM_BITS-1:0]          pos,
    output logic                                   last
);
    import capm_pkg::*;

    // Wide enough for both the size field and the full counter range.
    localparam int EW = ((DIM_BITS > SIZE_W) ? DIM_BITS : SIZE_W) + 1;
    localparam logic [EW-1:0] CAP = EW'(1) << DIM_BITS;

    logic [MAX_AXES-1:0][DIM_BITS-1:0] pos_reg, pos_next;
    logic [MAX_AXES:0] carry;

    // Step the counters as a ripple of wrap conditions.
    always_comb
    begin
        logic [EW-1:0] eff;
        logic [EW-1:0] inc;
        carry[0] = 1'b1;
        for (int a = 0; a < MAX_AXES; a++)
        begin
            if (a >= AXES || size[a] == '0)
                eff = EW'(1);
            else if (EW'(size[a]) > CAP)
                eff = CAP;
            else
                eff = EW'(size[a]);
            inc = EW'(pos_reg[a]) + EW'(1);
            if (!carry[a])
            begin
                pos_next[a] = pos_reg[a];
                carry[a+1]  = 1'b0;
            end
            else if (inc >= eff)
            begin
                pos_next[a] = '0;
                carry[a+1]  = 1'b1;
            end
            else
            begin
                pos_next[a] = inc[DIM_BITS-1:0];
                carry[a+1]  = 1'b0;
            end
        end
    end

    assign pos  = pos_reg;
    assign last = carry[MAX_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (advance)
            pos_reg <= pos_next;
    end

    for (genvar a = AXES; a < MAX_AXES; a++)
    begin : g_unused
        assert property (@(posedge clk) disable iff (!rst_n) pos_reg[a] == '0)
            else $error("unused axis counter moved");
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> pos_reg == '0)
        else $error("counters did not return to zero after last pixel");
endmodule

>>> rtl/capm_extrema.sv
// Module: running minimum and maximum over non-NaN pixels.
module capm_extrema (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [capm_pkg::PIX_W-1:0]    pixel,
    output logic [capm_pkg::PIX_W-1:0]    low_next,
    output logic [capm_pkg::PIX_W-1:0]    high_next,
    output logic                          have_next
);
    import capm_pkg::*;

    logic [PIX_W-1:0] low_reg, high_reg;
    logic             have_reg;

    // Update extrema with the incoming pixel unless it is NaN.
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        have_next = have_reg;
        if (!is_nan(pixel))
        begin
            have_next = 1'b1;
            if (!have_reg)
            begin
                low_next  = pixel;
                high_next = pixel;
            end
            else
            begin
                if (dbl_lt(pixel, low_reg))
                    low_next = pixel;
                if (dbl_lt(high_reg, pixel))
                    high_next = pixel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            have_reg <= 1'b0;
        end
        else if (advance)
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
            have_reg <= have_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !have_reg |-> low_reg == '0 && high_reg == '0)
        else $error("extrema nonzero before first value");
    assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |=> have_reg)
        else $error("extrema valid dropped");
endmodule

>>> rtl/cube_axis_permute_minmax_unit.sv
// Top level: cube axis permutation with running extrema and cube-end flag.
// A result is registered and appears in the cycle after its pixel is accepted.
// Throughput: one pixel per cycle unless the output stalls; the result
// register advances when empty or taken, so input ready follows output
// ready or an empty slot. Reset: counters, extrema and output valid clear;
// sizes reset to 1, sources to the identity permutation.
module cube_axis_permute_minmax_unit #(
    parameter int DIM_BITS = capm_pkg::DIM_BITS_DEF,
    parameter int AXES     = capm_pkg::AXES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [capm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [capm_pkg::CFG_DATA_W-1:0]   cfg_data,
    capm_stream_if.sink                       in_ch,
    capm_stream_if.source                     out_ch
);
    import capm_pkg::*;

    logic [MAX_AXES-1:0][SIZE_W-1:0]   size_reg;
    logic [MAX_AXES-1:0][SRC_W-1:0]    src_reg;
    logic [MAX_AXES-1:0][DIM_BITS-1:0] pos;
    logic                              last;
    logic                              advance;
    logic [PIX_W-1:0]                  pixel;
    logic [PIX_W-1:0]                  low_next, high_next;
    logic                              have_next;
    logic [MAX_AXES-1:0][COORD_W-1:0]  dest;
    result_t                           res_reg, res_next;
    logic                              out_valid_reg;

    assign pixel   = in_ch.payload;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign advance = in_ch.valid && in_ch.ready;

    // Write configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < MAX_AXES; a++)
            begin
                size_reg[a] <= SIZE_W'(1);
                src_reg[a]  <= SRC_W'(a);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SIZE0: size_reg[0] <= cfg_data;
                REG_SIZE1: size_reg[1] <= cfg_data;
                REG_SIZE2: size_reg[2] <= cfg_data;
                REG_SIZE3: size_reg[3] <= cfg_data;
                REG_SRC0:  src_reg[0]  <= cfg_data[SRC_W-1:0];
                REG_SRC1:  src_reg[1]  <= cfg_data[SRC_W-1:0];
                REG_SRC2:  src_reg[2]  <= cfg_data[SRC_W-1:0];
                REG_SRC3:  src_reg[3]  <= cfg_data[SRC_W-1:0];
                default: ;
            endcase
        end
    end

    capm_counter #(.DIM_BITS(DIM_BITS), .AXES(AXES)) u_counter (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .size    (size_reg),
        .pos     (pos),
        .last    (last)
    );

    capm_extrema u_extrema (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .pixel     (pixel),
        .low_next  (low_next),
        .high_next (high_next),
        .have_next (have_next)
    );

    // Select destination coordinates, masked to the field width.
    always_comb
    begin
        logic [COORD_W+DIM_BITS-1:0] wide;
        for (int a = 0; a < MAX_AXES; a++)
        begin
            wide    = (COORD_W+DIM_BITS)'(pos[src_reg[a]]);
            dest[a] = wide[COORD_W-1:0];
        end
    end

    always_comb
    begin
        res_next.dest_coord0   = dest[0];
        res_next.dest_coord1   = dest[1];
        res_next.dest_coord2   = dest[2];
        res_next.dest_coord3   = dest[3];
        res_next.value_bits    = is_nan(pixel) ? fill_pattern() : pixel;
        res_next.running_min   = low_next;
        res_next.running_max   = high_next;
        res_next.extrema_valid = have_next;
        res_next.cube_last     = last;
    end

    // Hold the result until taken; load a new one on each accepted pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ch.ready)
            out_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("accepted pixel produced no result");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while result stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.extrema_valid |->
        res_reg.running_min == '0 && res_reg.running_max == '0)
        else $error("extrema fields set without a value");
endmodule

>>> tb/tb.sv
// Testbench for the cube axis permute and min/max unit.
`timescale 1ns / 1ps

module tb;
    import capm_pkg::*;

    typedef logic [PIX_W-1:0] pix_t;

    // Directed stimulus row: pixel, plus an expected result where it is obvious.
    typedef struct {
        pix_t    pix;
        bit      typed;
        result_t exp;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    capm_stream_if #(.payload_t(pix_t))    in_ch ();
    capm_stream_if #(.payload_t(result_t)) out_ch ();

    cube_axis_permute_minmax_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Shadow copy of the block: configuration, coordinates and extrema.
    logic [SIZE_W-1:0]  axis_len [4];
    logic [SRC_W-1:0]   axis_src [4];
    logic [COORD_W-1:0] coord [4];
    pix_t               min_bits;
    pix_t               max_bits;
    bit                 seen_value;

    result_t pending_results [$];
    int      errors;
    bit      no_stall;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit pix_is_nan(pix_t b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    endfunction

    // Clamp a size register to the range the counters use.
    function automatic int clamp_len(logic [SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > 4096)
            return 4096;
        return s;
    endfunction

    // Compute the result for one pixel and advance the shadow state.
    function automatic result_t permute_pixel(pix_t px);
        result_t r;
        bit      carry;
        int      a;
        int      nxt;
        carry = 1'b1;
        r.dest_coord0 = coord[axis_src[0]];
        r.dest_coord1 = coord[axis_src[1]];
        r.dest_coord2 = coord[axis_src[2]];
        r.dest_coord3 = coord[axis_src[3]];
        if (pix_is_nan(px))
        begin
            r.value_bits = '1;
        end
        else
        begin
            r.value_bits = px;
            if (!seen_value)
            begin
                min_bits   = px;
                max_bits   = px;
                seen_value = 1'b1;
            end
            else
            begin
                if ($bitstoreal(px) < $bitstoreal(min_bits))
                    min_bits = px;
                if ($bitstoreal(px) > $bitstoreal(max_bits))
                    max_bits = px;
            end
        end
        // Ripple the raster counters, axis 0 fastest.
        for (a = 0; a < 4; a++)
        begin
            if (carry)
            begin
                nxt = int'(coord[a]) + 1;
                if (nxt >= clamp_len(axis_len[a]))
                    coord[a] = '0;
                else
                begin
                    coord[a] = nxt[COORD_W-1:0];
                    carry = 1'b0;
                end
            end
        end
        r.running_min   = min_bits;
        r.running_max   = max_bits;
        r.extrema_valid = seen_value;
        r.cube_last     = carry;
        return r;
    endfunction

    task automatic check_field(string name, logic [PIX_W-1:0] exp, logic [PIX_W-1:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %h, got %h", name, exp, act);
            errors++;
        end
    endtask

    // Drain results and compare against the oldest pending expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= no_stall || ($urandom_range(99) >= 10);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result transaction: %p", out_ch.payload);
                    errors++;
                end
                else
                begin
                    result_t e;
                    result_t g;
                    e = pending_results.pop_front();
                    g = out_ch.payload;
                    check_field("dest_coord0", e.dest_coord0, g.dest_coord0);
                    check_field("dest_coord1", e.dest_coord1, g.dest_coord1);
                    check_field("dest_coord2", e.dest_coord2, g.dest_coord2);
                    check_field("dest_coord3", e.dest_coord3, g.dest_coord3);
                    check_field("value_bits", e.value_bits, g.value_bits);
                    check_field("running_min", e.running_min, g.running_min);
                    check_field("running_max", e.running_max, g.running_max);
                    check_field("extrema_valid", e.extrema_valid, g.extrema_valid);
                    check_field("cube_last", e.cube_last, g.cube_last);
                end
            end
        end
    end

    // Send one pixel; record the expectation when the transaction is accepted.
    task automatic send_pixel(pix_t px, bit typed, result_t typed_exp);
        result_t r;
        if (!no_stall && $urandom_range(99) < 10)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= px;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        r = permute_pixel(px);
        pending_results.push_back(typed ? typed_exp : r);
    endtask

    // Hold off the sender until every pending result has come back.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx <= REG_SIZE3)
            axis_len[idx] = data;
        else
            axis_src[idx - REG_SRC0] = data[SRC_W-1:0];
    endtask

    task automatic set_shape(int s0, int s1, int s2, int s3,
                             int p0, int p1, int p2, int p3);
        write_reg(REG_SIZE0, s0[CFG_DATA_W-1:0]);
        write_reg(REG_SIZE1, s1[CFG_DATA_W-1:0]);
        write_reg(REG_SIZE2, s2[CFG_DATA_W-1:0]);
        write_reg(REG_SIZE3, s3[CFG_DATA_W-1:0]);
        write_reg(REG_SRC0, p0[CFG_DATA_W-1:0]);
        write_reg(REG_SRC1, p1[CFG_DATA_W-1:0]);
        write_reg(REG_SRC2, p2[CFG_DATA_W-1:0]);
        write_reg(REG_SRC3, p3[CFG_DATA_W-1:0]);
    endtask

    function automatic pix_t random_pixel();
        pix_t p;
        p = {$urandom, $urandom};
        case ($urandom_range(9))
            0: p[62:52] = 11'h7FF;                       // NaN or infinity
            1: p[62:0]  = '0;                            // signed zero
            2: p[62:52] = '0;                            // subnormal
            3: p = {1'b0, 11'h7FF, 52'h0};
            4: p = {1'b1, 11'h7FF, 52'h0};
            default: ;
        endcase
        return p;
    endfunction

    task automatic run_random(int count);
        result_t none;
        none = '0;
        repeat (count)
            send_pixel(random_pixel(), 1'b0, none);
    endtask

    initial
    begin
        #5_000_000;
        $display("[cube_axis_permute_minmax_unit] ERROR");
        $finish;
    end

    initial
    begin
        row_t    dir_rows [$];
        result_t none;
        int      i;
        int      p [4];
        int      t;
        int      j;
        none = '0;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        errors         = 0;
        no_stall       = 1'b0;
        for (i = 0; i < 4; i++)
        begin
            axis_len[i] = 1;
            axis_src[i] = i[SRC_W-1:0];
            coord[i]    = '0;
        end
        min_bits   = '0;
        max_bits   = '0;
        seen_value = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: NaN before any value, then extremes and signed zeros.
        dir_rows.push_back('{64'h7FF8_0000_0000_0000, 1'b1,
            '{0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 1'b0, 1'b1}});
        dir_rows.push_back('{64'h3FF0_0000_0000_0000, 1'b1,
            '{0, 0, 0, 0, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
              64'h3FF0_0000_0000_0000, 1'b1, 1'b1}});
        dir_rows.push_back('{64'h8000_0000_0000_0000, 1'b0, none});
        dir_rows.push_back('{64'h0000_0000_0000_0000, 1'b0, none});
        dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, none});
        dir_rows.push_back('{64'h7FF0_0000_0000_0001, 1'b0, none});
        dir_rows.push_back('{64'hFFF0_0000_0000_0000, 1'b0, none});
        dir_rows.push_back('{64'h7FF0_0000_0000_0000, 1'b0, none});
        dir_rows.push_back('{64'h7FEF_FFFF_FFFF_FFFF, 1'b0, none});
        dir_rows.push_back('{64'hFFEF_FFFF_FFFF_FFFF, 1'b0, none});
        dir_rows.push_back('{64'h0000_0000_0000_0001, 1'b0, none});
        dir_rows.push_back('{64'h8000_0000_0000_0001, 1'b0, none});
        dir_rows.push_back('{64'h5555_5555_5555_5555, 1'b0, none});
        dir_rows.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, none});
        foreach (dir_rows[k])
            send_pixel(dir_rows[k].pix, dir_rows[k].typed, dir_rows[k].exp);
        wait_idle();

        // Small 4-axis cube with a reversed axis order.
        set_shape(2, 3, 2, 2, 3, 2, 1, 0);
        run_random(30);
        wait_idle();

        // Size zero acts as one; duplicated source axes.
        set_shape(0, 3, 0, 2, 1, 1, 3, 3);
        run_random(14);
        wait_idle();

        // Oversize axis clamps; no stalls on either side here.
        no_stall = 1'b1;
        set_shape(8191, 1, 1, 1, 2, 0, 3, 1);
        run_random(300);
        wait_idle();
        no_stall = 1'b0;

        // Shrink the axis mid-cube so the counter sits past its size.
        set_shape(3, 2, 1, 1, 0, 1, 2, 3);
        run_random(20);
        wait_idle();

        // Random shapes and permutations.
        repeat (40)
        begin
            for (i = 0; i < 4; i++)
                p[i] = i;
            for (i = 3; i > 0; i--)
            begin
                j = $urandom_range(i);
                t = p[i];
                p[i] = p[j];
                p[j] = t;
            end
            if ($urandom_range(4) == 0)
                p[$urandom_range(3)] = $urandom_range(3);
            set_shape($urandom_range(6), $urandom_range(5), $urandom_range(4),
                      $urandom_range(3), p[0], p[1], p[2], p[3]);
            run_random($urandom_range(60, 20));
            wait_idle();
        end

        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("[cube_axis_permute_minmax_unit] OK");
        else
            $display("[cube_axis_permute_minmax_unit] ERROR");
        $finish;
    end
endmodule

>>> filelist.f
rtl/capm_pkg.sv
rtl/capm_stream_if.sv
rtl/capm_counter.sv
rtl/capm_extrema.sv
rtl/cube_axis_permute_minmax_unit.sv
tb/tb.sv
